// File: sv/aifs_pkg.sv
`timescale 1ns / 1ps
package aifs_pkg;

   localparam int ACC_BITS = 64;
   localparam int MAX_TOKEN_BYTES = 1023;
   localparam int CNT_W = $clog2(MAX_TOKEN_BYTES + 1);
   localparam int LIMIT_W = 10;
   localparam int LIM_CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam int VALUE_W = 64;
   localparam int STATUS_W = 2;
   localparam int TLEN_W = 10;
   localparam int MODE_W = 3;
   localparam int SIZE_W = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 10;

   localparam logic [MODE_W-1:0] MODE_SDEC = 3'd0;
   localparam logic [MODE_W-1:0] MODE_UDEC = 3'd1;
   localparam logic [MODE_W-1:0] MODE_OCT  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_HEX  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_AUTO = 3'd4;

   localparam logic [SIZE_W-1:0] SIZE_32 = 2'd0;
   localparam logic [SIZE_W-1:0] SIZE_16 = 2'd1;

   localparam logic [STATUS_W-1:0] STATUS_FIELD = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EOT   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BLANK = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SUPPRESS = 2'd3;

   localparam logic [1:0] PFX_NONE  = 2'd0;
   localparam logic [1:0] PFX_ZERO  = 2'd1;
   localparam logic [1:0] PFX_0X    = 2'd2;
   localparam logic [1:0] PFX_DIGIT = 2'd3;

   localparam logic [4:0] HEX_BAD = 5'd16;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [LIMIT_W-1:0] width_limit;
      logic [SIZE_W-1:0]  size;
      logic               suppress;
   } cfg_type;

   typedef struct packed {
      logic                valid;
      logic                is_field;
      logic [STATUS_W-1:0] status;
      logic [ACC_BITS-1:0] raw;
      logic                negate;
      logic [CNT_W-1:0]    count;
   } fin_type;

   function automatic logic is_blank(logic [7:0] c);
      return c == 8'd32 || c == 8'd9 || c == 8'd10 || c == 8'd11 || c == 8'd12 ||
             c == 8'd13;
   endfunction

   function automatic logic [4:0] hex_value(logic [7:0] c);
      logic [4:0] v;
      v = HEX_BAD;
      if (c >= "0" && c <= "9") v = 5'(c - "0");
      else if (c >= "a" && c <= "f") v = 5'(c - "a" + 8'd10);
      else if (c >= "A" && c <= "F") v = 5'(c - "A" + 8'd10);
      return v;
   endfunction

   function automatic logic signed_mode(logic [MODE_W-1:0] m);
      return m != MODE_UDEC && m != MODE_OCT && m != MODE_HEX;
   endfunction

endpackage

// File: sv/aifs_token_tracker.sv
`timescale 1ns / 1ps
module aifs_token_tracker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  logic [7:0]               text_byte,
   input  logic                     text_end,
   input  aifs_pkg::cfg_type        cfg,
   output aifs_pkg::fin_type        fin
);
   import aifs_pkg::*;

   logic [ACC_BITS-1:0] dec_ff, dec_in, oct_ff, oct_in, hex_ff, hex_in;
   logic                neg_ff, neg_in;
   logic [2:0]          stop_ff, stop_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                inside_ff, inside_in;
   logic [1:0]          prefix_ff, prefix_in;
   logic                hexl_ff, hexl_in;
   logic                nonblank_ff, nonblank_in;

   logic [ACC_BITS-1:0] b_dec, b_oct, b_hex, f_dec, f_oct, f_hex;
   logic                b_neg, f_neg, b_hexl, f_hexl;
   logic [2:0]          b_stop, f_stop;
   logic [CNT_W-1:0]    b_count, f_count;
   logic [1:0]          b_prefix, f_prefix;
   logic [4:0]          hv;
   logic                is_dec, is_oct, pos_zero, pos_one, blank;
   logic [LIM_CMP_W-1:0] limit;

   function automatic fin_type finish(
      input logic [ACC_BITS-1:0] d, input logic [ACC_BITS-1:0] o,
      input logic [ACC_BITS-1:0] h, input logic [1:0] pfx, input logic hl,
      input logic ng, input logic [CNT_W-1:0] cnt, input logic [MODE_W-1:0] m
   );
      fin_type f;
      logic    use_dec;
      f = '0;
      use_dec = 1'b0;
      unique case (m)
         MODE_UDEC: f.raw = d;
         MODE_OCT:  f.raw = o;
         MODE_HEX:  f.raw = h;
         MODE_AUTO: begin
            priority if (pfx == PFX_0X) f.raw = h;
            else if (pfx == PFX_ZERO) f.raw = o;
            else if (pfx == PFX_DIGIT && hl) f.raw = h;
            else begin
               f.raw = d;
               use_dec = 1'b1;
            end
         end
         default: begin
            f.raw = d;
            use_dec = 1'b1;
         end
      endcase
      f.valid = 1'b1;
      f.is_field = 1'b1;
      f.status = STATUS_FIELD;
      f.negate = use_dec && ng;
      f.count = cnt;
      return f;
   endfunction

   always_comb begin
      blank = is_blank(text_byte);
      hv = hex_value(text_byte);
      is_dec = text_byte >= "0" && text_byte <= "9";
      is_oct = text_byte >= "0" && text_byte <= "7";

      if (inside_ff) begin
         b_dec = dec_ff;
         b_oct = oct_ff;
         b_hex = hex_ff;
         b_neg = neg_ff;
         b_stop = stop_ff;
         b_count = count_ff;
         b_prefix = prefix_ff;
         b_hexl = hexl_ff;
      end else begin
         b_dec = '0;
         b_oct = '0;
         b_hex = '0;
         b_neg = 1'b0;
         b_stop = '0;
         b_count = '0;
         b_prefix = PFX_NONE;
         b_hexl = 1'b0;
      end
      pos_zero = b_count == '0;
      pos_one = b_count == CNT_W'(1);

      f_hexl = b_hexl | (hv >= 5'd10 && hv < HEX_BAD);
      f_dec = b_dec;
      f_oct = b_oct;
      f_hex = b_hex;
      f_neg = b_neg;
      f_stop = b_stop;
      f_prefix = b_prefix;

      if (!b_stop[0]) begin
         if (pos_zero && text_byte == "-" && signed_mode(cfg.mode)) f_neg = 1'b1;
         else if (is_dec)
            f_dec = (b_dec << 3) + (b_dec << 1) + ACC_BITS'(text_byte[3:0]);
         else f_stop[0] = 1'b1;
      end
      if (!b_stop[1]) begin
         if (is_oct) f_oct = {b_oct[ACC_BITS-4:0], text_byte[2:0]};
         else f_stop[1] = 1'b1;
      end
      if (pos_one && b_prefix == PFX_ZERO && (text_byte == "x" || text_byte == "X")) begin
         f_hex = '0;
         f_prefix = PFX_0X;
      end else if (!b_stop[2]) begin
         if (hv != HEX_BAD) f_hex = {b_hex[ACC_BITS-5:0], hv[3:0]};
         else f_stop[2] = 1'b1;
      end
      if (pos_zero) f_prefix = (text_byte == "0") ? PFX_ZERO : (is_dec ? PFX_DIGIT : PFX_NONE);
      f_count = b_count + CNT_W'(1);

      if (cfg.width_limit == '0 ||
          LIM_CMP_W'(cfg.width_limit) > LIM_CMP_W'(MAX_TOKEN_BYTES))
         limit = LIM_CMP_W'(MAX_TOKEN_BYTES);
      else limit = LIM_CMP_W'(cfg.width_limit);

      dec_in = dec_ff;
      oct_in = oct_ff;
      hex_in = hex_ff;
      neg_in = neg_ff;
      stop_in = stop_ff;
      count_in = count_ff;
      inside_in = inside_ff;
      prefix_in = prefix_ff;
      hexl_in = hexl_ff;
      nonblank_in = nonblank_ff;
      fin = '0;

      if (fire) begin
         priority if (text_end) begin
            if (inside_ff) begin
               fin = finish(dec_ff, oct_ff, hex_ff, prefix_ff, hexl_ff, neg_ff, count_ff,
                            cfg.mode);
               inside_in = 1'b0;
            end else begin
               fin.valid = 1'b1;
               fin.is_field = 1'b0;
               fin.status = nonblank_ff ? STATUS_EOT : STATUS_BLANK;
               nonblank_in = 1'b0;
            end
         end else if (blank) begin
            if (inside_ff) begin
               fin = finish(dec_ff, oct_ff, hex_ff, prefix_ff, hexl_ff, neg_ff, count_ff,
                            cfg.mode);
               inside_in = 1'b0;
            end
         end else begin
            nonblank_in = 1'b1;
            dec_in = f_dec;
            oct_in = f_oct;
            hex_in = f_hex;
            neg_in = f_neg;
            stop_in = f_stop;
            count_in = f_count;
            prefix_in = f_prefix;
            hexl_in = f_hexl;
            inside_in = 1'b1;
            if (LIM_CMP_W'(f_count) >= limit) begin
               fin = finish(f_dec, f_oct, f_hex, f_prefix, f_hexl, f_neg, f_count, cfg.mode);
               inside_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff <= '0;
         oct_ff <= '0;
         hex_ff <= '0;
         neg_ff <= 1'b0;
         stop_ff <= '0;
         count_ff <= '0;
         inside_ff <= 1'b0;
         prefix_ff <= PFX_NONE;
         hexl_ff <= 1'b0;
         nonblank_ff <= 1'b0;
      end else begin
         dec_ff <= dec_in;
         oct_ff <= oct_in;
         hex_ff <= hex_in;
         neg_ff <= neg_in;
         stop_ff <= stop_in;
         count_ff <= count_in;
         inside_ff <= inside_in;
         prefix_ff <= prefix_in;
         hexl_ff <= hexl_in;
         nonblank_ff <= nonblank_in;
      end
   end

endmodule

// File: sv/aifs_result_format.sv
`timescale 1ns / 1ps
module aifs_result_format (
   input  aifs_pkg::fin_type               fin,
   input  aifs_pkg::cfg_type               cfg,
   output logic [aifs_pkg::VALUE_W-1:0]    value_bits,
   output logic [aifs_pkg::STATUS_W-1:0]   status,
   output logic                            assigned,
   output logic [aifs_pkg::TLEN_W-1:0]     token_length
);
   import aifs_pkg::*;

   logic [ACC_BITS-1:0] acc;
   logic [VALUE_W-1:0]  wide, wrapped;
   logic                sgn;

   always_comb begin
      acc = fin.negate ? (~fin.raw + ACC_BITS'(1)) : fin.raw;
      wide = VALUE_W'(acc);
      sgn = signed_mode(cfg.mode);
      unique case (cfg.size)
         SIZE_32: wrapped = {{32{sgn & wide[31]}}, wide[31:0]};
         SIZE_16: wrapped = {{48{sgn & wide[15]}}, wide[15:0]};
         default: wrapped = wide;
      endcase

      status = fin.status;
      if (fin.is_field) begin
         token_length = TLEN_W'(fin.count);
         assigned = !cfg.suppress;
         value_bits = cfg.suppress ? '0 : wrapped;
      end else begin
         token_length = '0;
         assigned = 1'b0;
         value_bits = '0;
      end
   end

endmodule

// File: sv/ascii_integer_field_scanner_unit.sv
`timescale 1ns / 1ps
// a byte is accepted into the input register, its token update is registered in the token
// stage, and its result then shows on rsp_valid from the output register
// throughput: one byte per unstalled cycle, the whole token update fits between two registers
// a stalled output holds the pipeline; a byte slot is still taken while the input stage is free
// reset: synchronous, clears all token state, pipeline valids and registers to mode 0,
// no limit, 32-bit wrap, store enabled
module ascii_integer_field_scanner_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_text_byte,
   input  logic                            req_text_end,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [aifs_pkg::VALUE_W-1:0]    rsp_value_bits,
   output logic [aifs_pkg::STATUS_W-1:0]   rsp_status,
   output logic                            rsp_assigned,
   output logic [aifs_pkg::TLEN_W-1:0]     rsp_token_length,
   input  logic                            csr_write_enable,
   input  logic [aifs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [aifs_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import aifs_pkg::*;

   cfg_type             cfg_ff, cfg_in;
   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff, in_byte_in;
   logic                in_end_ff, in_end_in;
   fin_type             mid_ff, mid_in;
   logic                out_valid_ff, out_valid_in;
   logic [VALUE_W-1:0]  out_value_ff, out_value_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic                out_assigned_ff, out_assigned_in;
   logic [TLEN_W-1:0]   out_tlen_ff, out_tlen_in;

   logic                advance, fire;
   fin_type             fin;
   logic [VALUE_W-1:0]  fmt_value;
   logic [STATUS_W-1:0] fmt_status;
   logic                fmt_assigned;
   logic [TLEN_W-1:0]   fmt_tlen;

   assign advance = !(out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign fire = in_valid_ff && advance;

   aifs_token_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .text_byte (in_byte_ff),
      .text_end  (in_end_ff),
      .cfg       (cfg_ff),
      .fin       (fin)
   );

   aifs_result_format u_format (
      .fin          (mid_ff),
      .cfg          (cfg_ff),
      .value_bits   (fmt_value),
      .status       (fmt_status),
      .assigned     (fmt_assigned),
      .token_length (fmt_tlen)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MODE:     cfg_in.mode = csr_write_data[MODE_W-1:0];
            CSR_WIDTH:    cfg_in.width_limit = csr_write_data[LIMIT_W-1:0];
            CSR_SIZE:     cfg_in.size = csr_write_data[SIZE_W-1:0];
            CSR_SUPPRESS: cfg_in.suppress = csr_write_data[0];
         endcase
      end

      in_valid_in = in_valid_ff;
      in_byte_in = in_byte_ff;
      in_end_in = in_end_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_byte_in = req_text_byte;
         in_end_in = req_text_end;
      end

      mid_in = mid_ff;
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_status_in = out_status_ff;
      out_assigned_in = out_assigned_ff;
      out_tlen_in = out_tlen_ff;
      if (advance) begin
         mid_in = fin;
         out_valid_in = mid_ff.valid;
         out_value_in = fmt_value;
         out_status_in = fmt_status;
         out_assigned_in = fmt_assigned;
         out_tlen_in = fmt_tlen;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
         in_valid_ff <= 1'b0;
         mid_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         in_valid_ff <= in_valid_in;
         mid_ff <= mid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_end_ff <= in_end_in;
      out_value_ff <= out_value_in;
      out_status_ff <= out_status_in;
      out_assigned_ff <= out_assigned_in;
      out_tlen_ff <= out_tlen_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_value_bits = out_value_ff;
   assign rsp_status = out_status_ff;
   assign rsp_assigned = out_assigned_ff;
   assign rsp_token_length = out_tlen_ff;

   a_end_status_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_FIELD |->
         !rsp_assigned && rsp_token_length == '0 && rsp_value_bits == '0)
      else $error("end status item carries field data");

   a_suppressed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FIELD && !rsp_assigned |-> rsp_value_bits == '0)
      else $error("unassigned field has nonzero value");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_status == STATUS_FIELD || rsp_status == STATUS_EOT || rsp_status == STATUS_BLANK)
      else $error("bad status code");

   a_field_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FIELD |-> rsp_token_length != '0)
      else $error("field item with zero length");

   a_mid_holds: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall && in_valid_ff |=> $stable(mid_ff.valid) && in_valid_ff)
      else $error("pipeline moved while output stalled");

endmodule
